/* sv/rotation_matrix_to_quaternion_macros.svh */
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH

// same-cycle implication, off while in reset
`define RMQ_ASSERT_IMP(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while in reset
`define RMQ_ASSERT_NXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);

// checked during reset as well
`define RMQ_ASSERT_RST(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) (ant) |-> (cons)) \
		else $error(msg);

`endif

/* sv/rmq_pkg.sv */
package rmq_pkg;

	localparam int FRAC_BITS = 14;
	localparam int IN_W = 16;
	localparam int MAG_W = 15;
	localparam int NUM_LANES = 4;

	// diagonal sum: one plus three signed elements
	localparam int SUM_W = ((FRAC_BITS > IN_W + 1) ? FRAC_BITS : IN_W + 1) + 2;
	localparam int RAD_MIN = SUM_W - 1 + FRAC_BITS;

	// square root, two result bits per stage
	localparam int SQ_PER_STG = 2;
	localparam int NUM_SQ_STG = (RAD_MIN + 2 * SQ_PER_STG - 1) / (2 * SQ_PER_STG);
	localparam int ROOT_W = SQ_PER_STG * NUM_SQ_STG;
	localparam int RAD_W = 2 * ROOT_W;
	localparam int REM_W = ROOT_W + 3;

	// entry stage, root stages, output stage
	localparam int NUM_STG = NUM_SQ_STG + 2;

	localparam logic signed [SUM_W-1:0] ONE_SUM = SUM_W'(1) << FRAC_BITS;
	localparam logic [MAG_W-1:0] MAG_MAX = '1;

	// which diagonal terms are subtracted: bit 0 m00, bit 1 m11, bit 2 m22
	localparam logic [2:0] NEG_SEL_W = 3'b000;
	localparam logic [2:0] NEG_SEL_X = 3'b110;
	localparam logic [2:0] NEG_SEL_Y = 3'b101;
	localparam logic [2:0] NEG_SEL_Z = 3'b011;

	typedef struct packed {
		logic signed [IN_W-1:0] m00;
		logic signed [IN_W-1:0] m01;
		logic signed [IN_W-1:0] m02;
		logic signed [IN_W-1:0] m10;
		logic signed [IN_W-1:0] m11;
		logic signed [IN_W-1:0] m12;
		logic signed [IN_W-1:0] m20;
		logic signed [IN_W-1:0] m21;
		logic signed [IN_W-1:0] m22;
	} mat_t;

	typedef struct packed {
		logic [MAG_W-1:0] quat_w;
		logic signed [IN_W-1:0] quat_x;
		logic signed [IN_W-1:0] quat_y;
		logic signed [IN_W-1:0] quat_z;
	} quat_t;

	typedef struct packed {
		logic [RAD_W-1:0] rad;
		logic [REM_W-1:0] rem;
		logic [ROOT_W-1:0] root;
	} sq_t;

	typedef struct packed {
		logic [NUM_STG-1:0] load;
		logic out_valid;
	} pipe_ctl_t;

	function automatic sq_t sq_stage(sq_t cur);
		sq_t nxt;
		logic [REM_W-1:0] shifted;
		logic [REM_W-1:0] trial;
		nxt = cur;
		for (int j = 0; j < SQ_PER_STG; j++) begin
			shifted = {nxt.rem[REM_W-3:0], nxt.rad[RAD_W-1 -: 2]};
			trial = {1'b0, nxt.root, 2'b01};
			nxt.rad = {nxt.rad[RAD_W-3:0], 2'b00};
			if (shifted >= trial) begin
				nxt.rem = shifted - trial;
				nxt.root = {nxt.root[ROOT_W-2:0], 1'b1};
			end else begin
				nxt.rem = shifted;
				nxt.root = {nxt.root[ROOT_W-2:0], 1'b0};
			end
		end
		return nxt;
	endfunction

endpackage

/* sv/rmq_lane.sv */
module rmq_lane import rmq_pkg::*; (
	input  logic                   clk,
	input  logic [NUM_STG-2:0]     load,
	input  logic [2:0]             neg_sel,
	input  logic signed [IN_W-1:0] d0,
	input  logic signed [IN_W-1:0] d1,
	input  logic signed [IN_W-1:0] d2,
	input  logic signed [IN_W-1:0] p,
	input  logic signed [IN_W-1:0] q,
	output logic signed [IN_W-1:0] comp
);

	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] t0, t1, t2;
	logic [RAD_W-1:0] rad;
	logic signed [IN_W:0] diff;
	sq_t sq_s [NUM_SQ_STG+1];
	logic neg_s [NUM_SQ_STG+1];
	logic [ROOT_W:0] rnd;
	logic [ROOT_W-1:0] half;
	logic [MAG_W-1:0] mag;

	always_comb begin
		t0 = SUM_W'(d0);
		t1 = SUM_W'(d1);
		t2 = SUM_W'(d2);
		sum = ONE_SUM + (neg_sel[0] ? -t0 : t0) + (neg_sel[1] ? -t1 : t1)
			+ (neg_sel[2] ? -t2 : t2);
		// clamp non-positive sums to zero
		if (!sum[SUM_W-1] && (sum != '0)) begin
			rad = RAD_W'(sum[SUM_W-2:0]) << FRAC_BITS;
		end else begin
			rad = '0;
		end
		diff = (IN_W+1)'(p) - (IN_W+1)'(q);
	end

	always_ff @(posedge clk) begin
		if (load[0]) begin
			sq_s[0].rad <= rad;
			sq_s[0].rem <= '0;
			sq_s[0].root <= '0;
			neg_s[0] <= diff[IN_W];
		end
		for (int k = 0; k < NUM_SQ_STG; k++) begin
			if (load[k+1]) begin
				sq_s[k+1] <= sq_stage(sq_s[k]);
				neg_s[k+1] <= neg_s[k];
			end
		end
	end

	// round half up, saturate, apply sign
	always_comb begin
		rnd = {1'b0, sq_s[NUM_SQ_STG].root} + (ROOT_W+1)'(1);
		half = rnd[ROOT_W:1];
		mag = (half > ROOT_W'(MAG_MAX)) ? MAG_MAX : half[MAG_W-1:0];
		comp = neg_s[NUM_SQ_STG] ? (IN_W'(0) - {1'b0, mag}) : {1'b0, mag};
	end

endmodule

/* sv/rmq_ctrl.sv */
module rmq_ctrl import rmq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      out_stall,
	output logic      in_stall,
	output pipe_ctl_t ctl
);

	logic [NUM_STG-1:0] vld_q;
	logic [NUM_STG-1:0] rdy;

	// a stage takes a beat when empty or when the next one moves on
	always_comb begin
		rdy[NUM_STG-1] = !vld_q[NUM_STG-1] || !out_stall;
		for (int i = NUM_STG - 2; i >= 0; i--) begin
			rdy[i] = !vld_q[i] || rdy[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int i = 1; i < NUM_STG; i++) begin
				if (rdy[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	assign in_stall = !rdy[0];
	assign ctl.load = rdy;
	assign ctl.out_valid = vld_q[NUM_STG-1];

endmodule

/* sv/rmq_merge.sv */
module rmq_merge import rmq_pkg::*; (
	input  logic                   clk,
	input  logic                   load,
	input  logic signed [IN_W-1:0] comp_w,
	input  logic signed [IN_W-1:0] comp_x,
	input  logic signed [IN_W-1:0] comp_y,
	input  logic signed [IN_W-1:0] comp_z,
	output quat_t                  quat
);

	quat_t quat_q;

	// w lane is never negative, so its sign bit is dropped
	always_ff @(posedge clk) begin
		if (load) begin
			quat_q.quat_w <= comp_w[MAG_W-1:0];
			quat_q.quat_x <= comp_x;
			quat_q.quat_y <= comp_y;
			quat_q.quat_z <= comp_z;
		end
	end

	assign quat = quat_q;

endmodule

/* sv/rotation_matrix_to_quaternion.sv */
// channel | dir | handshake             | beat
// --------+-----+-----------------------+-----------------------------
// mat     | in  | mat_valid, mat_stall  | nine matrix elements, Q2.14
// quat    | out | quat_valid, quat_stall| quaternion x, y, z Q2.14, w unsigned Q1.14
//
// one matrix per cycle while mat_stall is low; the pipeline has
// one stage for the diagonal sums, one per two root bits, one output register
// four root lanes run side by side; the output register merges them
// arst_n clears only the stage valid bits
// quat_stall holds the output; upstream stages keep filling bubbles until full
module rotation_matrix_to_quaternion import rmq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  mat_valid,
	output logic  mat_stall,
	input  mat_t  mat,
	output logic  quat_valid,
	input  logic  quat_stall,
	output quat_t quat
);

	pipe_ctl_t ctl;
	logic signed [IN_W-1:0] comp_w, comp_x, comp_y, comp_z;

	rmq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (mat_valid),
		.out_stall(quat_stall),
		.in_stall (mat_stall),
		.ctl      (ctl)
	);

	rmq_lane u_lane_w (
		.clk    (clk),
		.load   (ctl.load[NUM_STG-2:0]),
		.neg_sel(NEG_SEL_W),
		.d0     (mat.m00),
		.d1     (mat.m11),
		.d2     (mat.m22),
		.p      ('0),
		.q      ('0),
		.comp   (comp_w)
	);

	rmq_lane u_lane_x (
		.clk    (clk),
		.load   (ctl.load[NUM_STG-2:0]),
		.neg_sel(NEG_SEL_X),
		.d0     (mat.m00),
		.d1     (mat.m11),
		.d2     (mat.m22),
		.p      (mat.m21),
		.q      (mat.m12),
		.comp   (comp_x)
	);

	rmq_lane u_lane_y (
		.clk    (clk),
		.load   (ctl.load[NUM_STG-2:0]),
		.neg_sel(NEG_SEL_Y),
		.d0     (mat.m00),
		.d1     (mat.m11),
		.d2     (mat.m22),
		.p      (mat.m02),
		.q      (mat.m20),
		.comp   (comp_y)
	);

	rmq_lane u_lane_z (
		.clk    (clk),
		.load   (ctl.load[NUM_STG-2:0]),
		.neg_sel(NEG_SEL_Z),
		.d0     (mat.m00),
		.d1     (mat.m11),
		.d2     (mat.m22),
		.p      (mat.m10),
		.q      (mat.m01),
		.comp   (comp_z)
	);

	rmq_merge u_merge (
		.clk   (clk),
		.load  (ctl.load[NUM_STG-1]),
		.comp_w(comp_w),
		.comp_x(comp_x),
		.comp_y(comp_y),
		.comp_z(comp_z),
		.quat  (quat)
	);

	assign quat_valid = ctl.out_valid;

endmodule

/* sv/rmq_checker.sv */
`include "rotation_matrix_to_quaternion_macros.svh"

module rmq_checker import rmq_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  mat_valid,
	input logic  mat_stall,
	input mat_t  mat,
	input logic  quat_valid,
	input logic  quat_stall,
	input quat_t quat
);

	// held beat stays put
	`RMQ_ASSERT_NXT(a_out_hold, quat_valid && quat_stall, quat_valid && $stable(quat), "quat beat changed while stalled")

	// stalled input beat stays put
	`RMQ_ASSERT_NXT(a_in_hold, mat_valid && mat_stall, mat_valid && $stable(mat), "mat beat changed while stalled")

	// input backs up only behind a stalled full output
	`RMQ_ASSERT_IMP(a_stall_cause, mat_stall, quat_valid && quat_stall, "mat stalled without a stalled output beat")

	// saturation keeps signed parts off the most negative code
	`RMQ_ASSERT_IMP(a_no_min, quat_valid, (quat.quat_x != 16'sh8000) && (quat.quat_y != 16'sh8000) && (quat.quat_z != 16'sh8000), "quaternion part at most negative code")

	// nothing leaves while in reset
	`RMQ_ASSERT_RST(a_rst_quiet, !arst_n, !quat_valid, "quat_valid high during reset")

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (.*);
